### sv/hhe_pkg.sv
// Package with shared types, constants and the static Huffman code table.
package hhe_pkg;

  localparam int unsigned OctetBits = 8;
  localparam int unsigned CodeWidth = 30;
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned AccWidth  = 37;
  localparam int unsigned TotWidth  = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_PAD
  } state_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic [LenWidth-1:0]  len;
  } code_entry_t;

  function automatic code_entry_t code_lookup(input logic [7:0] sym);
    logic [31:0] c;
    logic [4:0]  l;
    code_entry_t e;
    unique case (sym)
      8'd0: begin c = 32'h1ff8; l = 5'd13; end
      8'd1: begin c = 32'h7fffd8; l = 5'd23; end
      8'd2: begin c = 32'hfffffe2; l = 5'd28; end
      8'd3: begin c = 32'hfffffe3; l = 5'd28; end
      8'd4: begin c = 32'hfffffe4; l = 5'd28; end
      8'd5: begin c = 32'hfffffe5; l = 5'd28; end
      8'd6: begin c = 32'hfffffe6; l = 5'd28; end
      8'd7: begin c = 32'hfffffe7; l = 5'd28; end
      8'd8: begin c = 32'hfffffe8; l = 5'd28; end
      8'd9: begin c = 32'hffffea; l = 5'd24; end
      8'd10: begin c = 32'h3ffffffc; l = 5'd30; end
      8'd11: begin c = 32'hfffffe9; l = 5'd28; end
      8'd12: begin c = 32'hfffffea; l = 5'd28; end
      8'd13: begin c = 32'h3ffffffd; l = 5'd30; end
      8'd14: begin c = 32'hfffffeb; l = 5'd28; end
      8'd15: begin c = 32'hfffffec; l = 5'd28; end
      8'd16: begin c = 32'hfffffed; l = 5'd28; end
      8'd17: begin c = 32'hfffffee; l = 5'd28; end
      8'd18: begin c = 32'hfffffef; l = 5'd28; end
      8'd19: begin c = 32'hffffff0; l = 5'd28; end
      8'd20: begin c = 32'hffffff1; l = 5'd28; end
      8'd21: begin c = 32'hffffff2; l = 5'd28; end
      8'd22: begin c = 32'h3ffffffe; l = 5'd30; end
      8'd23: begin c = 32'hffffff3; l = 5'd28; end
      8'd24: begin c = 32'hffffff4; l = 5'd28; end
      8'd25: begin c = 32'hffffff5; l = 5'd28; end
      8'd26: begin c = 32'hffffff6; l = 5'd28; end
      8'd27: begin c = 32'hffffff7; l = 5'd28; end
      8'd28: begin c = 32'hffffff8; l = 5'd28; end
      8'd29: begin c = 32'hffffff9; l = 5'd28; end
      8'd30: begin c = 32'hffffffa; l = 5'd28; end
      8'd31: begin c = 32'hffffffb; l = 5'd28; end
      8'd32: begin c = 32'h14; l = 5'd6; end
      8'd33: begin c = 32'h3f8; l = 5'd10; end
      8'd34: begin c = 32'h3f9; l = 5'd10; end
      8'd35: begin c = 32'hffa; l = 5'd12; end
      8'd36: begin c = 32'h1ff9; l = 5'd13; end
      8'd37: begin c = 32'h15; l = 5'd6; end
      8'd38: begin c = 32'hf8; l = 5'd8; end
      8'd39: begin c = 32'h7fa; l = 5'd11; end
      8'd40: begin c = 32'h3fa; l = 5'd10; end
      8'd41: begin c = 32'h3fb; l = 5'd10; end
      8'd42: begin c = 32'hf9; l = 5'd8; end
      8'd43: begin c = 32'h7fb; l = 5'd11; end
      8'd44: begin c = 32'hfa; l = 5'd8; end
      8'd45: begin c = 32'h16; l = 5'd6; end
      8'd46: begin c = 32'h17; l = 5'd6; end
      8'd47: begin c = 32'h18; l = 5'd6; end
      8'd48: begin c = 32'h0; l = 5'd5; end
      8'd49: begin c = 32'h1; l = 5'd5; end
      8'd50: begin c = 32'h2; l = 5'd5; end
      8'd51: begin c = 32'h19; l = 5'd6; end
      8'd52: begin c = 32'h1a; l = 5'd6; end
      8'd53: begin c = 32'h1b; l = 5'd6; end
      8'd54: begin c = 32'h1c; l = 5'd6; end
      8'd55: begin c = 32'h1d; l = 5'd6; end
      8'd56: begin c = 32'h1e; l = 5'd6; end
      8'd57: begin c = 32'h1f; l = 5'd6; end
      8'd58: begin c = 32'h5c; l = 5'd7; end
      8'd59: begin c = 32'hfb; l = 5'd8; end
      8'd60: begin c = 32'h7ffc; l = 5'd15; end
      8'd61: begin c = 32'h20; l = 5'd6; end
      8'd62: begin c = 32'hffb; l = 5'd12; end
      8'd63: begin c = 32'h3fc; l = 5'd10; end
      8'd64: begin c = 32'h1ffa; l = 5'd13; end
      8'd65: begin c = 32'h21; l = 5'd6; end
      8'd66: begin c = 32'h5d; l = 5'd7; end
      8'd67: begin c = 32'h5e; l = 5'd7; end
      8'd68: begin c = 32'h5f; l = 5'd7; end
      8'd69: begin c = 32'h60; l = 5'd7; end
      8'd70: begin c = 32'h61; l = 5'd7; end
      8'd71: begin c = 32'h62; l = 5'd7; end
      8'd72: begin c = 32'h63; l = 5'd7; end
      8'd73: begin c = 32'h64; l = 5'd7; end
      8'd74: begin c = 32'h65; l = 5'd7; end
      8'd75: begin c = 32'h66; l = 5'd7; end
      8'd76: begin c = 32'h67; l = 5'd7; end
      8'd77: begin c = 32'h68; l = 5'd7; end
      8'd78: begin c = 32'h69; l = 5'd7; end
      8'd79: begin c = 32'h6a; l = 5'd7; end
      8'd80: begin c = 32'h6b; l = 5'd7; end
      8'd81: begin c = 32'h6c; l = 5'd7; end
      8'd82: begin c = 32'h6d; l = 5'd7; end
      8'd83: begin c = 32'h6e; l = 5'd7; end
      8'd84: begin c = 32'h6f; l = 5'd7; end
      8'd85: begin c = 32'h70; l = 5'd7; end
      8'd86: begin c = 32'h71; l = 5'd7; end
      8'd87: begin c = 32'h72; l = 5'd7; end
      8'd88: begin c = 32'hfc; l = 5'd8; end
      8'd89: begin c = 32'h73; l = 5'd7; end
      8'd90: begin c = 32'hfd; l = 5'd8; end
      8'd91: begin c = 32'h1ffb; l = 5'd13; end
      8'd92: begin c = 32'h7fff0; l = 5'd19; end
      8'd93: begin c = 32'h1ffc; l = 5'd13; end
      8'd94: begin c = 32'h3ffc; l = 5'd14; end
      8'd95: begin c = 32'h22; l = 5'd6; end
      8'd96: begin c = 32'h7ffd; l = 5'd15; end
      8'd97: begin c = 32'h3; l = 5'd5; end
      8'd98: begin c = 32'h23; l = 5'd6; end
      8'd99: begin c = 32'h4; l = 5'd5; end
      8'd100: begin c = 32'h24; l = 5'd6; end
      8'd101: begin c = 32'h5; l = 5'd5; end
      8'd102: begin c = 32'h25; l = 5'd6; end
      8'd103: begin c = 32'h26; l = 5'd6; end
      8'd104: begin c = 32'h27; l = 5'd6; end
      8'd105: begin c = 32'h6; l = 5'd5; end
      8'd106: begin c = 32'h74; l = 5'd7; end
      8'd107: begin c = 32'h75; l = 5'd7; end
      8'd108: begin c = 32'h28; l = 5'd6; end
      8'd109: begin c = 32'h29; l = 5'd6; end
      8'd110: begin c = 32'h2a; l = 5'd6; end
      8'd111: begin c = 32'h7; l = 5'd5; end
      8'd112: begin c = 32'h2b; l = 5'd6; end
      8'd113: begin c = 32'h76; l = 5'd7; end
      8'd114: begin c = 32'h2c; l = 5'd6; end
      8'd115: begin c = 32'h8; l = 5'd5; end
      8'd116: begin c = 32'h9; l = 5'd5; end
      8'd117: begin c = 32'h2d; l = 5'd6; end
      8'd118: begin c = 32'h77; l = 5'd7; end
      8'd119: begin c = 32'h78; l = 5'd7; end
      8'd120: begin c = 32'h79; l = 5'd7; end
      8'd121: begin c = 32'h7a; l = 5'd7; end
      8'd122: begin c = 32'h7b; l = 5'd7; end
      8'd123: begin c = 32'h7ffe; l = 5'd15; end
      8'd124: begin c = 32'h7fc; l = 5'd11; end
      8'd125: begin c = 32'h3ffd; l = 5'd14; end
      8'd126: begin c = 32'h1ffd; l = 5'd13; end
      8'd127: begin c = 32'hffffffc; l = 5'd28; end
      8'd128: begin c = 32'hfffe6; l = 5'd20; end
      8'd129: begin c = 32'h3fffd2; l = 5'd22; end
      8'd130: begin c = 32'hfffe7; l = 5'd20; end
      8'd131: begin c = 32'hfffe8; l = 5'd20; end
      8'd132: begin c = 32'h3fffd3; l = 5'd22; end
      8'd133: begin c = 32'h3fffd4; l = 5'd22; end
      8'd134: begin c = 32'h3fffd5; l = 5'd22; end
      8'd135: begin c = 32'h7fffd9; l = 5'd23; end
      8'd136: begin c = 32'h3fffd6; l = 5'd22; end
      8'd137: begin c = 32'h7fffda; l = 5'd23; end
      8'd138: begin c = 32'h7fffdb; l = 5'd23; end
      8'd139: begin c = 32'h7fffdc; l = 5'd23; end
      8'd140: begin c = 32'h7fffdd; l = 5'd23; end
      8'd141: begin c = 32'h7fffde; l = 5'd23; end
      8'd142: begin c = 32'hffffeb; l = 5'd24; end
      8'd143: begin c = 32'h7fffdf; l = 5'd23; end
      8'd144: begin c = 32'hffffec; l = 5'd24; end
      8'd145: begin c = 32'hffffed; l = 5'd24; end
      8'd146: begin c = 32'h3fffd7; l = 5'd22; end
      8'd147: begin c = 32'h7fffe0; l = 5'd23; end
      8'd148: begin c = 32'hffffee; l = 5'd24; end
      8'd149: begin c = 32'h7fffe1; l = 5'd23; end
      8'd150: begin c = 32'h7fffe2; l = 5'd23; end
      8'd151: begin c = 32'h7fffe3; l = 5'd23; end
      8'd152: begin c = 32'h7fffe4; l = 5'd23; end
      8'd153: begin c = 32'h1fffdc; l = 5'd21; end
      8'd154: begin c = 32'h3fffd8; l = 5'd22; end
      8'd155: begin c = 32'h7fffe5; l = 5'd23; end
      8'd156: begin c = 32'h3fffd9; l = 5'd22; end
      8'd157: begin c = 32'h7fffe6; l = 5'd23; end
      8'd158: begin c = 32'h7fffe7; l = 5'd23; end
      8'd159: begin c = 32'hffffef; l = 5'd24; end
      8'd160: begin c = 32'h3fffda; l = 5'd22; end
      8'd161: begin c = 32'h1fffdd; l = 5'd21; end
      8'd162: begin c = 32'hfffe9; l = 5'd20; end
      8'd163: begin c = 32'h3fffdb; l = 5'd22; end
      8'd164: begin c = 32'h3fffdc; l = 5'd22; end
      8'd165: begin c = 32'h7fffe8; l = 5'd23; end
      8'd166: begin c = 32'h7fffe9; l = 5'd23; end
      8'd167: begin c = 32'h1fffde; l = 5'd21; end
      8'd168: begin c = 32'h7fffea; l = 5'd23; end
      8'd169: begin c = 32'h3fffdd; l = 5'd22; end
      8'd170: begin c = 32'h3fffde; l = 5'd22; end
      8'd171: begin c = 32'hfffff0; l = 5'd24; end
      8'd172: begin c = 32'h1fffdf; l = 5'd21; end
      8'd173: begin c = 32'h3fffdf; l = 5'd22; end
      8'd174: begin c = 32'h7fffeb; l = 5'd23; end
      8'd175: begin c = 32'h7fffec; l = 5'd23; end
      8'd176: begin c = 32'h1fffe0; l = 5'd21; end
      8'd177: begin c = 32'h1fffe1; l = 5'd21; end
      8'd178: begin c = 32'h3fffe0; l = 5'd22; end
      8'd179: begin c = 32'h1fffe2; l = 5'd21; end
      8'd180: begin c = 32'h7fffed; l = 5'd23; end
      8'd181: begin c = 32'h3fffe1; l = 5'd22; end
      8'd182: begin c = 32'h7fffee; l = 5'd23; end
      8'd183: begin c = 32'h7fffef; l = 5'd23; end
      8'd184: begin c = 32'hfffea; l = 5'd20; end
      8'd185: begin c = 32'h3fffe2; l = 5'd22; end
      8'd186: begin c = 32'h3fffe3; l = 5'd22; end
      8'd187: begin c = 32'h3fffe4; l = 5'd22; end
      8'd188: begin c = 32'h7ffff0; l = 5'd23; end
      8'd189: begin c = 32'h3fffe5; l = 5'd22; end
      8'd190: begin c = 32'h3fffe6; l = 5'd22; end
      8'd191: begin c = 32'h7ffff1; l = 5'd23; end
      8'd192: begin c = 32'h3ffffe0; l = 5'd26; end
      8'd193: begin c = 32'h3ffffe1; l = 5'd26; end
      8'd194: begin c = 32'hfffeb; l = 5'd20; end
      8'd195: begin c = 32'h7fff1; l = 5'd19; end
      8'd196: begin c = 32'h3fffe7; l = 5'd22; end
      8'd197: begin c = 32'h7ffff2; l = 5'd23; end
      8'd198: begin c = 32'h3fffe8; l = 5'd22; end
      8'd199: begin c = 32'h1ffffec; l = 5'd25; end
      8'd200: begin c = 32'h3ffffe2; l = 5'd26; end
      8'd201: begin c = 32'h3ffffe3; l = 5'd26; end
      8'd202: begin c = 32'h3ffffe4; l = 5'd26; end
      8'd203: begin c = 32'h7ffffde; l = 5'd27; end
      8'd204: begin c = 32'h7ffffdf; l = 5'd27; end
      8'd205: begin c = 32'h3ffffe5; l = 5'd26; end
      8'd206: begin c = 32'hfffff1; l = 5'd24; end
      8'd207: begin c = 32'h1ffffed; l = 5'd25; end
      8'd208: begin c = 32'h7fff2; l = 5'd19; end
      8'd209: begin c = 32'h1fffe3; l = 5'd21; end
      8'd210: begin c = 32'h3ffffe6; l = 5'd26; end
      8'd211: begin c = 32'h7ffffe0; l = 5'd27; end
      8'd212: begin c = 32'h7ffffe1; l = 5'd27; end
      8'd213: begin c = 32'h3ffffe7; l = 5'd26; end
      8'd214: begin c = 32'h7ffffe2; l = 5'd27; end
      8'd215: begin c = 32'hfffff2; l = 5'd24; end
      8'd216: begin c = 32'h1fffe4; l = 5'd21; end
      8'd217: begin c = 32'h1fffe5; l = 5'd21; end
      8'd218: begin c = 32'h3ffffe8; l = 5'd26; end
      8'd219: begin c = 32'h3ffffe9; l = 5'd26; end
      8'd220: begin c = 32'hffffffd; l = 5'd28; end
      8'd221: begin c = 32'h7ffffe3; l = 5'd27; end
      8'd222: begin c = 32'h7ffffe4; l = 5'd27; end
      8'd223: begin c = 32'h7ffffe5; l = 5'd27; end
      8'd224: begin c = 32'hfffec; l = 5'd20; end
      8'd225: begin c = 32'hfffff3; l = 5'd24; end
      8'd226: begin c = 32'hfffed; l = 5'd20; end
      8'd227: begin c = 32'h1fffe6; l = 5'd21; end
      8'd228: begin c = 32'h3fffe9; l = 5'd22; end
      8'd229: begin c = 32'h1fffe7; l = 5'd21; end
      8'd230: begin c = 32'h1fffe8; l = 5'd21; end
      8'd231: begin c = 32'h7ffff3; l = 5'd23; end
      8'd232: begin c = 32'h3fffea; l = 5'd22; end
      8'd233: begin c = 32'h3fffeb; l = 5'd22; end
      8'd234: begin c = 32'h1ffffee; l = 5'd25; end
      8'd235: begin c = 32'h1ffffef; l = 5'd25; end
      8'd236: begin c = 32'hfffff4; l = 5'd24; end
      8'd237: begin c = 32'hfffff5; l = 5'd24; end
      8'd238: begin c = 32'h3ffffea; l = 5'd26; end
      8'd239: begin c = 32'h7ffff4; l = 5'd23; end
      8'd240: begin c = 32'h3ffffeb; l = 5'd26; end
      8'd241: begin c = 32'h7ffffe6; l = 5'd27; end
      8'd242: begin c = 32'h3ffffec; l = 5'd26; end
      8'd243: begin c = 32'h3ffffed; l = 5'd26; end
      8'd244: begin c = 32'h7ffffe7; l = 5'd27; end
      8'd245: begin c = 32'h7ffffe8; l = 5'd27; end
      8'd246: begin c = 32'h7ffffe9; l = 5'd27; end
      8'd247: begin c = 32'h7ffffea; l = 5'd27; end
      8'd248: begin c = 32'h7ffffeb; l = 5'd27; end
      8'd249: begin c = 32'hffffffe; l = 5'd28; end
      8'd250: begin c = 32'h7ffffec; l = 5'd27; end
      8'd251: begin c = 32'h7ffffed; l = 5'd27; end
      8'd252: begin c = 32'h7ffffee; l = 5'd27; end
      8'd253: begin c = 32'h7ffffef; l = 5'd27; end
      8'd254: begin c = 32'h7fffff0; l = 5'd27; end
      default: begin c = 32'h3ffffee; l = 5'd26; end
    endcase
    e.code = c[CodeWidth-1:0];
    e.len  = l;
    return e;
  endfunction

endpackage

### sv/hhe_stream_if.sv
// Valid/ready stream interface carrying one word of a parameterized payload type.
interface hhe_stream_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/hpack_huffman_encoder_core.sv
// Top level of the HPACK static Huffman encoder.
// Channel in: one word per raw octet (symbol, last_symbol). Channel out: one
// word per encoded octet (out_byte, end_of_run, end_of_message).
// An accepted symbol is looked up in the constant code table and merged with
// the up to 7 bits left over from earlier symbols in a 37-bit accumulator.
// One octet is taken off per cycle by a shared shifter while the receiver
// keeps up. An item is loaded in ST_IDLE, then ST_EMIT takes off each full
// octet it yields (0 to 4) and is passed through even when no octet
// completes, then ST_PAD adds the padding octet when a string ends with bits
// left over. An item yields 0 to 5 words in all.
// in.ready is low while an item is in work. The output register holds each
// word until the receiver takes it; a stall simply holds the sequencer.
// Synchronous reset clears the carry and returns the sequencer to idle with
// no word pending.
module hpack_huffman_encoder_core (
  input logic    clk,
  input logic    rst,
  hhe_stream_if.sink   in,
  hhe_stream_if.source out
);
  import hhe_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [6:0]          carry_bits;
  logic [2:0]          carry_count;
  logic                last_q;
  logic                load;
  logic                step;
  logic [TotWidth-1:0] total;
  logic [7:0]          octet;
  logic [7:0]          pad_octet;
  logic [6:0]          rem_bits;
  logic                out_valid;
  logic [9:0]          out_data;
  logic                more;
  logic                out_free;
  code_entry_t         entry;

  assign entry = code_lookup(in.data[8:1]);

  hhe_shifter u_shift (
    .clk         (clk),
    .load        (load),
    .step        (step),
    .carry_bits  (carry_bits),
    .carry_count (carry_count),
    .entry       (entry),
    .total       (total),
    .octet       (octet),
    .pad_octet   (pad_octet),
    .rem_bits    (rem_bits)
  );

  // Another full octet is waiting after the one now taken.
  assign more = (total >= TotWidth'(2 * OctetBits));
  assign out_free = !out_valid || out.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in.valid) state_next = ST_EMIT;
      ST_EMIT: begin
        if (total < TotWidth'(OctetBits)) begin
          state_next = (last_q && total != '0) ? ST_PAD : ST_IDLE;
        end else if (out_free && !more) begin
          state_next = (last_q && total[2:0] != 3'd0) ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready = (state == ST_IDLE);
    load     = (state == ST_IDLE) && in.valid;
    step     = (state == ST_EMIT) && out_free && (total >= TotWidth'(OctetBits));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      carry_bits  <= '0;
      carry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load) last_q <= in.data[0];
      if (step) begin
        out_valid   <= 1'b1;
        out_data[9:2] <= octet;
        // Last word of this item if nothing follows and no pad will come.
        out_data[1] <= !more && !(last_q && total[2:0] != 3'd0);
        out_data[0] <= !more && last_q && total[2:0] == 3'd0;
      end else if (state == ST_PAD && out_free) begin
        out_valid     <= 1'b1;
        out_data[9:2] <= pad_octet;
        out_data[1]   <= 1'b1;
        out_data[0]   <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
      if (state_next == ST_IDLE && state != ST_IDLE) begin
        carry_bits  <= last_q ? 7'd0 : rem_bits;
        carry_count <= last_q ? 3'd0 : total[2:0];
      end
    end
  end

  assign out.valid = out_valid;
  assign out.data  = out_data;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in.ready) else $error("busy accept");
  a_carry_small: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && total < TotWidth'(OctetBits)) |=> (state != ST_EMIT))
    else $error("emit stuck");
  a_pad_eom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && out_free) |=> (out_valid && out_data[0]))
    else $error("pad word missing");
  a_eom_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[0]) |-> out_data[1]) else $error("eom without eor");
endmodule

### sv/hhe_shifter.sv
// Bit accumulator: loads carry plus code, then peels one octet per step.
module hhe_shifter (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [6:0]                   carry_bits,
  input  logic [2:0]                   carry_count,
  input  hhe_pkg::code_entry_t         entry,
  output logic [hhe_pkg::TotWidth-1:0] total,
  output logic [7:0]                   octet,
  output logic [7:0]                   pad_octet,
  output logic [6:0]                   rem_bits
);
  import hhe_pkg::*;

  logic [AccWidth-1:0] acc;
  logic [AccWidth-1:0] acc_next;
  logic [TotWidth-1:0] total_next;
  logic [TotWidth-1:0] tot_sub;
  logic [AccWidth-1:0] shifted;
  logic [2:0]          rem_n;
  logic [7:0]          ones_mask;

  assign tot_sub = total - TotWidth'(OctetBits);
  assign shifted = acc >> tot_sub;
  assign octet   = shifted[7:0];
  assign rem_n   = total[2:0];
  assign rem_bits = acc[6:0] & ((7'd1 << rem_n) - 7'd1);
  // Remaining bits move to the top of the octet, ones fill the rest.
  assign ones_mask = (8'd1 << (4'd8 - {1'b0, rem_n})) - 8'd1;
  assign pad_octet = ({1'b0, rem_bits} << (4'd8 - {1'b0, rem_n})) | ones_mask;

  always_comb begin
    acc_next   = acc;
    total_next = total;
    if (load) begin
      acc_next   = (AccWidth'(carry_bits) << entry.len) | AccWidth'(entry.code);
      total_next = TotWidth'(carry_count) + TotWidth'(entry.len);
    end else if (step) begin
      total_next = tot_sub;
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    total <= total_next;
  end
endmodule

### verif/hhe_tb_pkg.sv
// Word formats of the input and output channels as seen by the testbench.
package hhe_tb_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } sym_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_message;
  } enc_word_t;

endpackage

### verif/hhe_encode_checker.sv
// Checker that predicts the encoded octet stream and compares every output word.
module hhe_encode_checker
  import hhe_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hhe_stream_if       in_ch,
  hhe_stream_if       out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam byte unsigned CodeLen [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
    6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
    5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
    13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
    7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
    15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
    6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

  logic [29:0] code_rom [256];
  logic [6:0]  carry_bits;
  logic [2:0]  carry_count;
  enc_word_t   octet_queue [$];

  // The static code is canonical, so the code words follow from the lengths:
  // codes of one length count up in symbol order, then shift left one bit.
  initial begin
    logic [29:0] next_code;
    next_code = '0;
    for (int len = 5; len <= 30; len++) begin
      for (int s = 0; s < 256; s++) begin
        if (CodeLen[s] == len) begin
          code_rom[s] = next_code;
          next_code++;
        end
      end
      next_code = next_code << 1;
    end
  end

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic encode_symbol(input sym_word_t w);
    logic [63:0] acc;
    int          total;
    int          len;
    int          first;
    enc_word_t   e;
    len   = CodeLen[w.symbol];
    acc   = (64'(carry_bits) << len) | 64'(code_rom[w.symbol]);
    total = int'(carry_count) + len;
    first = octet_queue.size();
    while (total >= 8) begin
      total -= 8;
      e.out_byte       = 8'(acc >> total);
      e.end_of_run     = 1'b0;
      e.end_of_message = 1'b0;
      octet_queue = {octet_queue, e};
    end
    acc &= (64'd1 << total) - 1;
    if (w.last_symbol) begin
      // Pad the tail with the leading ones of the EOS code.
      if (total > 0) begin
        e.out_byte       = 8'((acc << (8 - total)) | ((64'd1 << (8 - total)) - 1));
        e.end_of_run     = 1'b0;
        e.end_of_message = 1'b0;
        octet_queue = {octet_queue, e};
      end
      carry_bits  = '0;
      carry_count = '0;
    end else begin
      carry_bits  = 7'(acc);
      carry_count = 3'(total);
    end
    if (octet_queue.size() > first) begin
      octet_queue[$].end_of_run     = 1'b1;
      octet_queue[$].end_of_message = w.last_symbol;
    end
  endtask

  always @(posedge clk) begin
    enc_word_t got;
    enc_word_t want;
    if (rst) begin
      carry_bits  = '0;
      carry_count = '0;
      octet_queue.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (octet_queue.size() == 0) begin
          report($sformatf("unexpected word byte=%02h", got.out_byte));
        end else begin
          want = octet_queue.pop_front();
          if (got.out_byte != want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
          if (got.end_of_run != want.end_of_run)
            report($sformatf("end_of_run %0b, expected %0b", got.end_of_run,
                             want.end_of_run));
          if (got.end_of_message != want.end_of_message)
            report($sformatf("end_of_message %0b, expected %0b", got.end_of_message,
                             want.end_of_message));
        end
      end
      if (in_ch.valid && in_ch.ready) encode_symbol(in_ch.data);
    end
    pending = octet_queue.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

### verif/tb_hpack_huffman_encoder_core.sv
// Testbench top: clock, reset, symbol stimulus, receiver stalls and verdict.
module tb_hpack_huffman_encoder_core;
  import hhe_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  hhe_stream_if #(.payload_t(sym_word_t)) in_ch (.clk(clk));
  hhe_stream_if #(.payload_t(enc_word_t)) out_ch (.clk(clk));

  hpack_huffman_encoder_core u_top (
    .clk(clk),
    .rst(rst),
    .in (in_ch.sink),
    .out(out_ch.source)
  );

  hhe_encode_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 72;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic last);
    sym_word_t w;
    logic      taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    w.symbol      = sym;
    w.last_symbol = last;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    // Ready is looked at mid-cycle, where it is stable.
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_string(input int unsigned n);
    logic [7:0] sym;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       sym = 8'($urandom_range(255));
        1:       sym = 8'($urandom_range(31));
        default: sym = 8'($urandom_range(126, 32));
      endcase
      send_symbol(sym, i == n - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-symbol strings at the code extremes: 13-bit, 26-bit, 30-bit, 5-bit.
    send_symbol(8'd0, 1'b1);
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd10, 1'b1);
    send_symbol(8'd48, 1'b1);
    // An 8-bit code that ends exactly on an octet boundary needs no padding.
    send_symbol(8'd38, 1'b1);
    // Short codes whose bits wait in the carry; not every one completes an octet.
    send_symbol(8'd48, 1'b0);
    send_symbol(8'd97, 1'b0);
    send_symbol(8'd101, 1'b0);
    send_symbol(8'd49, 1'b1);
    // A 30-bit code on top of a 7-bit carry yields the most octets.
    send_symbol(8'd58, 1'b0);
    send_symbol(8'd22, 1'b0);
    send_symbol(8'd13, 1'b1);
    // Two 28-bit codes landing on the boundary, then alternating-bit symbols.
    send_symbol(8'd2, 1'b0);
    send_symbol(8'd127, 1'b0);
    send_symbol(8'd85, 1'b0);
    send_symbol(8'd170, 1'b1);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 10; rx_idle_pct = 72; end
        1: begin tx_idle_pct = 72; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (sent < 77 * (phase + 1)) begin
        n = $urandom_range(8, 1);
        send_string(n);
        sent += n;
      end
    end
    in_ch.valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
